FILE: hw/rtl/rhs_pkg.sv
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants of the reflow heater sequencer
// Register indexes, reset values, profile table and the state bundles that
// travel between the relay, profile and panel logic.
// ----------------------------------------------------------------------------
package rhs_pkg;

   // configuration register indexes
   localparam logic [1:0] CFG_WINDOW     = 2'd0;
   localparam logic [1:0] CFG_MIN_SWITCH = 2'd1;
   localparam logic [1:0] CFG_FLOOR      = 2'd2;

   // configuration reset values
   localparam logic [15:0] WINDOW_RST     = 16'd2000;
   localparam logic [9:0]  MIN_SWITCH_RST = 10'd25;
   localparam logic [7:0]  FLOOR_RST      = 8'd4;

   localparam logic [7:0] DRIVE_FULL = 8'd255;

   // modes
   localparam logic [1:0] MODE_INFO    = 2'd0;
   localparam logic [1:0] MODE_PROFILE = 2'd1;
   localparam logic [1:0] MODE_CUSTOM  = 2'd2;

   // phases
   localparam logic [2:0] PHASE_READY   = 3'd0;
   localparam logic [2:0] PHASE_PREHEAT = 3'd1;
   localparam logic [2:0] PHASE_SOAK    = 3'd2;
   localparam logic [2:0] PHASE_REFLOW  = 3'd3;
   localparam logic [2:0] PHASE_COOL    = 3'd4;

   localparam logic [8:0] TARGET_RST = 9'd40;
   localparam logic [8:0] TARGET_MAX = 9'd511;

   // profile phase ends, in milliseconds of elapsed time
   localparam logic [31:0] END_RAMP_MS    = 32'd20000;
   localparam logic [31:0] END_PREHEAT_MS = 32'd60000;
   localparam logic [31:0] END_SOAK_MS    = 32'd120000;
   localparam logic [31:0] END_REFLOW_MS  = 32'd160000;
   // from 162 s on the progress clamps at full scale
   localparam logic [31:0] PCT_SAT_MS     = 32'd162000;
   localparam logic [6:0]  PCT_FULL       = 7'd100;

   // divide by 1000 as (x >> 3) * ceil(2^21 / 125) >> 21, exact below 162000
   localparam logic [14:0] RECIP_125 = 15'd16778;
   localparam int          RECIP_SHIFT = 21;

   // profile table values
   localparam logic [8:0] TEMP_RAMP    = 9'd80;
   localparam logic [8:0] TEMP_PREHEAT = 9'd150;
   localparam logic [8:0] TEMP_SOAK    = 9'd180;
   localparam logic [8:0] TEMP_REFLOW  = 9'd230;
   localparam logic [5:0] LEN_RAMP     = 6'd20;
   localparam logic [5:0] LEN_PREHEAT  = 6'd40;
   localparam logic [5:0] LEN_SOAK     = 6'd60;
   localparam logic [5:0] LEN_REFLOW   = 6'd40;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [9:0]  min_switch_ms;
      logic [7:0]  drive_floor;
   } cfg_type;

   typedef struct packed {
      logic        relay;
      logic        heating;
      logic [31:0] heat_start;
      logic [31:0] cool_start;
      logic [31:0] last_switch;
   } relay_type;

   typedef struct packed {
      logic [8:0] target;
      logic [2:0] phase;
      logic [5:0] phase_len;
      logic [6:0] progress;
      logic       done;
   } prof_type;

   typedef struct packed {
      logic        running;
      logic [1:0]  mode;
      logic [8:0]  target;
      logic [31:0] run_start;
   } panel_type;

endpackage

FILE: hw/rtl/rhs_relay.sv
// ----------------------------------------------------------------------------
// rhs_relay: time-proportioning relay decision
// Next relay state for one pass from the drive level, window and switch
// hold-off; forces the relay off while the sequencer is selecting.
// ----------------------------------------------------------------------------
module rhs_relay import rhs_pkg::*; (
   input  logic        running,
   input  logic [31:0] now_ms,
   input  logic [7:0]  drive_level,
   input  cfg_type     cfg,
   input  relay_type   cur,
   output relay_type   nxt
);

   logic [31:0] since_sw;
   logic [31:0] on_t;
   logic [31:0] off_t;
   logic [39:0] on_x255;
   logic [39:0] off_x255;
   logic [7:0]  drive_rest;
   logic [23:0] win_on;
   logic [23:0] win_off;
   logic        blocked;

   // elapsed times, modulo 2^32
   assign since_sw = now_ms - cur.last_switch;
   assign on_t     = now_ms - cur.heat_start;
   assign off_t    = now_ms - cur.cool_start;
   assign blocked  = since_sw < {22'd0, cfg.min_switch_ms};

   // scale times by 255 as a shift and subtract
   assign on_x255  = {on_t, 8'd0} - {8'd0, on_t};
   assign off_x255 = {off_t, 8'd0} - {8'd0, off_t};

   assign drive_rest = DRIVE_FULL - drive_level;
   assign win_on     = {8'd0, cfg.window_ms} * {16'd0, drive_level};
   assign win_off    = {8'd0, cfg.window_ms} * {16'd0, drive_rest};

   // pick the edge, if any
   always_comb begin
      nxt = cur;
      if (!running) begin
         nxt.relay = 1'b0;
      end else if (!blocked) begin
         if (cur.heating && (drive_level != DRIVE_FULL)) begin
            if (on_x255 > {16'd0, win_on}) begin
               nxt.relay       = 1'b0;
               nxt.heating     = 1'b0;
               nxt.cool_start  = now_ms;
               nxt.last_switch = now_ms;
            end
         end else if (drive_level > cfg.drive_floor) begin
            if (off_x255 > {16'd0, win_off}) begin
               nxt.relay       = 1'b1;
               nxt.heating     = 1'b1;
               nxt.heat_start  = now_ms;
               nxt.last_switch = now_ms;
            end
         end
      end
   end

endmodule

FILE: hw/rtl/rhs_profile.sv
// ----------------------------------------------------------------------------
// rhs_profile: fixed four-phase reflow profile
// Target, phase, phase length and progress from the time since run start.
// ----------------------------------------------------------------------------
module rhs_profile import rhs_pkg::*; (
   input  logic [31:0] elapsed_ms,
   output prof_type    prof
);

   logic [14:0] eighths;
   logic [29:0] prod;
   logic [7:0]  secs;
   logic [9:0]  secs_x5;

   // whole seconds, valid while below the progress clamp
   assign eighths = elapsed_ms[17:3];
   assign prod    = {15'd0, eighths} * {15'd0, RECIP_125};
   assign secs    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
   assign secs_x5 = {secs, 2'd0} + {2'd0, secs};

   // phase table
   always_comb begin
      prof.done = 1'b0;
      if (elapsed_ms < END_RAMP_MS) begin
         prof.target = TEMP_RAMP;    prof.phase = PHASE_PREHEAT; prof.phase_len = LEN_RAMP;
      end else if (elapsed_ms < END_PREHEAT_MS) begin
         prof.target = TEMP_PREHEAT; prof.phase = PHASE_PREHEAT; prof.phase_len = LEN_PREHEAT;
      end else if (elapsed_ms < END_SOAK_MS) begin
         prof.target = TEMP_SOAK;    prof.phase = PHASE_SOAK;    prof.phase_len = LEN_SOAK;
      end else if (elapsed_ms < END_REFLOW_MS) begin
         prof.target = TEMP_REFLOW;  prof.phase = PHASE_REFLOW;  prof.phase_len = LEN_REFLOW;
      end else begin
         prof.target    = 9'd0;
         prof.phase     = PHASE_COOL;
         prof.phase_len = 6'd0;
         prof.done      = 1'b1;
      end
      // progress is secs * 5 / 8, clamped at full scale
      if (elapsed_ms < PCT_SAT_MS) begin
         prof.progress = secs_x5[9:3];
      end else begin
         prof.progress = PCT_FULL;
      end
   end

endmodule

FILE: hw/rtl/rhs_panel.sv
// ----------------------------------------------------------------------------
// rhs_panel: button handling
// Start/stop toggle, mode stepping while selecting and custom target
// trimming while running, applied in start, down, up order.
// ----------------------------------------------------------------------------
module rhs_panel import rhs_pkg::*; (
   input  logic [31:0] now_ms,
   input  logic        press_start,
   input  logic        press_down,
   input  logic        press_up,
   input  panel_type   cur,
   output panel_type   nxt
);

   logic       run;
   logic [1:0] mode_a;
   logic [8:0] tgt_a;

   always_comb begin
      nxt = cur;
      run = cur.running;

      // toggle running, stamp the start
      if (press_start) begin
         run = !cur.running;
         if (!cur.running) begin
            nxt.run_start = now_ms;
         end
      end
      nxt.running = run;

      // step down
      mode_a = cur.mode;
      tgt_a  = cur.target;
      if (press_down) begin
         if (!run) begin
            mode_a = (cur.mode == MODE_INFO) ? MODE_CUSTOM : cur.mode - 2'd1;
         end else if ((cur.mode == MODE_CUSTOM) && (cur.target != 9'd0)) begin
            tgt_a = cur.target - 9'd1;
         end
      end

      // step up
      nxt.mode   = mode_a;
      nxt.target = tgt_a;
      if (press_up) begin
         if (!run) begin
            nxt.mode = (mode_a >= MODE_CUSTOM) ? MODE_INFO : mode_a + 2'd1;
         end else if ((mode_a == MODE_CUSTOM) && (tgt_a != TARGET_MAX)) begin
            nxt.target = tgt_a + 9'd1;
         end
      end
   end

endmodule

FILE: hw/rtl/reflow_heater_sequencer.sv
// ----------------------------------------------------------------------------
// reflow_heater_sequencer: relay driver and reflow profile sequencer
// Input register, one pass of relay, profile and button logic, and the
// sequencer state that doubles as the result register.
// ----------------------------------------------------------------------------
// Each request beat is one control pass and yields one response beat. A beat
// is taken into an input register, and the pass runs once the response
// register is empty or being drained; its result is registered in the
// sequencer state that forms the response. Throughput is one beat per clock
// while the receiver does not stall, bounded by the loop through the relay
// and profile state. Configuration writes take effect at the next clock and
// should only be issued while no beat is in flight.
module reflow_heater_sequencer import rhs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_drive_level,
   input  logic        req_press_start,
   input  logic        req_press_down,
   input  logic        req_press_up,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_relay_on,
   output logic        rsp_is_running,
   output logic [1:0]  rsp_mode_now,
   output logic [8:0]  rsp_target_celsius,
   output logic [2:0]  rsp_phase_code,
   output logic [5:0]  rsp_phase_seconds,
   output logic [6:0]  rsp_progress_pct,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type     cfg_ff;
   logic        in_vld_ff;
   logic [31:0] in_now_ff;
   logic [7:0]  in_drive_ff;
   logic        in_start_ff;
   logic        in_down_ff;
   logic        in_up_ff;
   logic        out_vld_ff;
   logic        advance;

   relay_type   relay_ff;
   relay_type   relay_in;
   panel_type   panel_ff;
   panel_type   panel_pre;
   panel_type   panel_in;
   prof_type    prof;
   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [5:0]  len_ff;
   logic [5:0]  len_in;
   logic [6:0]  pct_ff;
   logic [6:0]  pct_in;
   logic        do_prof;

   // run a pass when the response slot frees up
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms     <= WINDOW_RST;
         cfg_ff.min_switch_ms <= MIN_SWITCH_RST;
         cfg_ff.drive_floor   <= FLOOR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_WINDOW:     cfg_ff.window_ms     <= csr_wdata;
            CFG_MIN_SWITCH: cfg_ff.min_switch_ms <= csr_wdata[9:0];
            CFG_FLOOR:      cfg_ff.drive_floor   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff   <= req_now_ms;
         in_drive_ff <= req_drive_level;
         in_start_ff <= req_press_start;
         in_down_ff  <= req_press_down;
         in_up_ff    <= req_press_up;
      end
   end

   // relay control
   rhs_relay u_relay (
      .running     (panel_ff.running),
      .now_ms      (in_now_ff),
      .drive_level (in_drive_ff),
      .cfg         (cfg_ff),
      .cur         (relay_ff),
      .nxt         (relay_in)
   );

   // profile update, only while running the profile mode
   rhs_profile u_profile (
      .elapsed_ms (in_now_ff - panel_ff.run_start),
      .prof       (prof)
   );

   assign do_prof = panel_ff.running && (panel_ff.mode == MODE_PROFILE);

   always_comb begin
      panel_pre = panel_ff;
      phase_in  = phase_ff;
      len_in    = len_ff;
      pct_in    = pct_ff;
      if (do_prof) begin
         panel_pre.target = prof.target;
         phase_in         = prof.phase;
         len_in           = prof.phase_len;
         pct_in           = prof.progress;
         if (prof.done) begin
            panel_pre.running = 1'b0;
         end
      end
   end

   // buttons
   rhs_panel u_panel (
      .now_ms      (in_now_ff),
      .press_start (in_start_ff),
      .press_down  (in_down_ff),
      .press_up    (in_up_ff),
      .cur         (panel_pre),
      .nxt         (panel_in)
   );

   // sequencer state, also the response payload
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff          <= 1'b0;
         relay_ff            <= '0;
         panel_ff.running    <= 1'b0;
         panel_ff.mode       <= MODE_INFO;
         panel_ff.target     <= TARGET_RST;
         panel_ff.run_start  <= 32'd0;
         phase_ff            <= PHASE_READY;
         len_ff              <= 6'd0;
         pct_ff              <= 7'd0;
      end else begin
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         if (advance) begin
            relay_ff <= relay_in;
            panel_ff <= panel_in;
            phase_ff <= phase_in;
            len_ff   <= len_in;
            pct_ff   <= pct_in;
         end
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_relay_on       = relay_ff.relay;
   assign rsp_is_running     = panel_ff.running;
   assign rsp_mode_now       = panel_ff.mode;
   assign rsp_target_celsius = panel_ff.target;
   assign rsp_phase_code     = phase_ff;
   assign rsp_phase_seconds  = len_ff;
   assign rsp_progress_pct   = pct_ff;

   // a pass that starts while selecting leaves the relay off
   a_idle_relay_off: assert property (@(posedge clock) disable iff (reset)
      (advance && !panel_ff.running) |=> !relay_ff.relay)
      else $error("relay turned on from a selecting pass");

   // the request side stalls only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && out_vld_ff && !rsp_ready))
      else $error("request stalled without a held response");

   // progress never passes full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_progress_pct <= PCT_FULL))
      else $error("progress above full scale");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the reflow heater sequencer
// Drives control passes through the request channel. A pass-level model of
// the relay, profile and panel logic predicts each response beat, and the
// bench checks every beat field by field. The run covers several register
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   import rhs_pkg::*;

   // index past the end of the register list, ignored by the block
   localparam logic [1:0] CFG_UNUSED = 2'd3;

   typedef struct packed {
      logic       relay;
      logic       running;
      logic [1:0] mode;
      logic [8:0] target;
      logic [2:0] phase;
      logic [5:0] phase_len;
      logic [6:0] progress;
   } pass_result_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [31:0] req_now_ms         = '0;
   logic [7:0]  req_drive_level    = '0;
   logic        req_press_start    = 1'b0;
   logic        req_press_down     = 1'b0;
   logic        req_press_up       = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic        rsp_relay_on;
   logic        rsp_is_running;
   logic [1:0]  rsp_mode_now;
   logic [8:0]  rsp_target_celsius;
   logic [2:0]  rsp_phase_code;
   logic [5:0]  rsp_phase_seconds;
   logic [6:0]  rsp_progress_pct;
   logic        csr_wr_en          = 1'b0;
   logic [1:0]  csr_index          = CFG_WINDOW;
   logic [15:0] csr_wdata          = '0;

   // register copies
   logic [15:0] cfg_window = WINDOW_RST;
   logic [9:0]  cfg_min_sw = MIN_SWITCH_RST;
   logic [7:0]  cfg_floor  = FLOOR_RST;

   // sequencer state as the model sees it
   logic        sim_relay     = 1'b0;
   logic        sim_heating   = 1'b0;
   logic [31:0] sim_heat_t0   = '0;
   logic [31:0] sim_cool_t0   = '0;
   logic [31:0] sim_last_sw   = '0;
   logic [31:0] sim_run_t0    = '0;
   logic        sim_running   = 1'b0;
   logic [1:0]  sim_mode      = MODE_INFO;
   logic [8:0]  sim_target    = TARGET_RST;
   logic [2:0]  sim_phase     = PHASE_READY;
   logic [5:0]  sim_phase_len = '0;
   logic [6:0]  sim_progress  = '0;

   pass_result_type pass_expect_q[$];
   int unsigned  items_sent   = 0;
   int unsigned  err_count    = 0;
   int unsigned  snd_idle_pct = 0;
   int unsigned  stall_pct    = 0;
   logic [31:0]  stamp_ms     = '0;

   reflow_heater_sequencer u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("reflow_heater_sequencer test failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // model of one control pass; updates the state and returns the response
   // --------------------------------------------------------------------------
   function automatic pass_result_type heat_pass(input logic [31:0] now,
                                                 input logic [7:0]  drive,
                                                 input logic        p_start,
                                                 input logic        p_down,
                                                 input logic        p_up);
      logic [31:0]  dt;
      logic [63:0]  span;
      logic [63:0]  win;
      logic [63:0]  drv;
      logic [31:0]  secs;
      logic [63:0]  pct;
      pass_result_type r;
      win = {48'd0, cfg_window};
      drv = {56'd0, drive};
      if (sim_running) begin
         // relay: hold off while inside the minimum switch time
         dt = now - sim_last_sw;
         if (dt >= {22'd0, cfg_min_sw}) begin
            if (sim_heating && drive != DRIVE_FULL) begin
               dt   = now - sim_heat_t0;
               span = {32'd0, dt};
               if (span * 64'd255 > win * drv) begin
                  sim_relay   = 1'b0;
                  sim_heating = 1'b0;
                  sim_cool_t0 = now;
                  sim_last_sw = now;
               end
            end else if (drive > cfg_floor) begin
               dt   = now - sim_cool_t0;
               span = {32'd0, dt};
               if (span * 64'd255 > win * (64'd255 - drv)) begin
                  sim_relay   = 1'b1;
                  sim_heating = 1'b1;
                  sim_heat_t0 = now;
                  sim_last_sw = now;
               end
            end
         end
         // profile table on whole elapsed seconds
         if (sim_mode == MODE_PROFILE) begin
            dt   = now - sim_run_t0;
            secs = dt / 32'd1000;
            if (secs < 20) begin
               sim_target = 9'd80;  sim_phase = PHASE_PREHEAT; sim_phase_len = 6'd20;
            end else if (secs < 60) begin
               sim_target = 9'd150; sim_phase = PHASE_PREHEAT; sim_phase_len = 6'd40;
            end else if (secs < 120) begin
               sim_target = 9'd180; sim_phase = PHASE_SOAK;    sim_phase_len = 6'd60;
            end else if (secs < 160) begin
               sim_target = 9'd230; sim_phase = PHASE_REFLOW;  sim_phase_len = 6'd40;
            end else begin
               sim_target = 9'd0;   sim_phase = PHASE_COOL;    sim_phase_len = 6'd0;
               sim_running = 1'b0;
            end
            pct = {32'd0, secs} * 64'd100 / 64'd160;
            sim_progress = (pct > 64'd100) ? PCT_FULL : pct[6:0];
         end
      end else begin
         sim_relay = 1'b0;
      end
      // panel buttons: start, down, up
      if (p_start) begin
         if (sim_running) begin
            sim_running = 1'b0;
         end else begin
            sim_running = 1'b1;
            sim_run_t0  = now;
         end
      end
      if (p_down) begin
         if (!sim_running)
            sim_mode = (sim_mode == MODE_INFO) ? MODE_CUSTOM : sim_mode - 2'd1;
         else if (sim_mode == MODE_CUSTOM && sim_target != 9'd0)
            sim_target = sim_target - 9'd1;
      end
      if (p_up) begin
         if (!sim_running)
            sim_mode = (sim_mode >= MODE_CUSTOM) ? MODE_INFO : sim_mode + 2'd1;
         else if (sim_mode == MODE_CUSTOM && sim_target != TARGET_MAX)
            sim_target = sim_target + 9'd1;
      end
      r.relay     = sim_relay;
      r.running   = sim_running;
      r.mode      = sim_mode;
      r.target    = sim_target;
      r.phase     = sim_phase;
      r.phase_len = sim_phase_len;
      r.progress  = sim_progress;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // checking
   // --------------------------------------------------------------------------
   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (err_count < 100)
         $display("MISMATCH %s: got %0d expected %0d (beat %0d)", field, got, want,
                  items_sent);
      err_count++;
   endtask

   // stall the response channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin : score_beats
      pass_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pass_expect_q.size() == 0) begin
            flag_mismatch("beat with nothing expected", 0, 0);
         end else begin
            want = pass_expect_q.pop_front();
            if (rsp_relay_on !== want.relay)
               flag_mismatch("relay_on", rsp_relay_on, want.relay);
            if (rsp_is_running !== want.running)
               flag_mismatch("is_running", rsp_is_running, want.running);
            if (rsp_mode_now !== want.mode)
               flag_mismatch("mode_now", rsp_mode_now, want.mode);
            if (rsp_target_celsius !== want.target)
               flag_mismatch("target_celsius", rsp_target_celsius, want.target);
            if (rsp_phase_code !== want.phase)
               flag_mismatch("phase_code", rsp_phase_code, want.phase);
            if (rsp_phase_seconds !== want.phase_len)
               flag_mismatch("phase_seconds", rsp_phase_seconds, want.phase_len);
            if (rsp_progress_pct !== want.progress)
               flag_mismatch("progress_pct", rsp_progress_pct, want.progress);
         end
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   // send one pass; predict it once the beat is taken
   task automatic send_pass(input logic [31:0] now, input logic [7:0] drive,
                            input logic p_start, input logic p_down, input logic p_up);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_now_ms      <= now;
      req_drive_level <= drive;
      req_press_start <= p_start;
      req_press_down  <= p_down;
      req_press_up    <= p_up;
      do @(posedge clock); while (!req_ready);
      pass_expect_q.push_back(heat_pass(now, drive, p_start, p_down, p_up));
      items_sent++;
   endtask

   // drop valid and hold until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pass_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CFG_WINDOW:     cfg_window = data;
         CFG_MIN_SWITCH: cfg_min_sw = data[9:0];
         CFG_FLOOR:      cfg_floor  = data[7:0];
         default: ;
      endcase
   endtask

   // program all registers with junk in the unused upper bits
   task automatic set_config(input logic [15:0] win, input logic [9:0] min_sw,
                             input logic [7:0] floor_lvl);
      logic [15:0] junk;
      junk = 16'($urandom());
      wait_drained();
      write_csr(CFG_WINDOW, win);
      write_csr(CFG_MIN_SWITCH, {junk[15:10], min_sw});
      write_csr(CFG_FLOOR, {junk[7:0], floor_lvl});
      write_csr(CFG_UNUSED, 16'($urandom()));
   endtask

   // drive levels leaning on the edges of the relay decisions
   function automatic logic [7:0] pick_drive();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return DRIVE_FULL;
         2:       return cfg_floor;
         3:       return cfg_floor + 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one run: pick a mode, start, then advance time with random content
   task automatic run_episode();
      logic [31:0] step_max;
      if (sim_running) send_pass(stamp_ms, pick_drive(), 1'b1, 1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) begin
         stamp_ms += $urandom_range(0, 500);
         if ($urandom_range(0, 1)) send_pass(stamp_ms, pick_drive(), 1'b0, 1'b1, 1'b0);
         else                      send_pass(stamp_ms, pick_drive(), 1'b0, 1'b0, 1'b1);
      end
      case ($urandom_range(0, 7))
         0:       stamp_ms = $urandom();
         1:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
         default: stamp_ms += $urandom_range(0, 5000);
      endcase
      send_pass(stamp_ms, pick_drive(), 1'b1, 1'b0, 1'b0);
      case ($urandom_range(0, 3))
         0:       step_max = 40;
         1:       step_max = 800;
         default: step_max = 3000;
      endcase
      repeat ($urandom_range(20, 160)) begin
         stamp_ms += $urandom_range(0, step_max);
         send_pass(stamp_ms, pick_drive(), $urandom_range(0, 63) == 0,
                   $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      end
   endtask

   // a burst of passes with every field random
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_pass($urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------
   // panel stepping, a full profile across the timestamp wrap, custom floor
   task automatic test_panel_and_profile();
      logic [31:0] t0;
      t0 = 32'hFFFE_0000;
      send_pass(32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      send_pass(32'hFFFF_FFFF, DRIVE_FULL, 1'b0, 1'b1, 1'b0);
      send_pass(32'd1, 8'd0, 1'b0, 1'b0, 1'b1);
      send_pass(32'd2, DRIVE_FULL, 1'b0, 1'b1, 1'b1);
      send_pass(32'd3, 8'd0, 1'b0, 1'b0, 1'b1);
      // profile run; full drive keeps restarting the on time
      send_pass(t0, DRIVE_FULL, 1'b1, 1'b0, 1'b0);
      send_pass(t0 + 10, DRIVE_FULL, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 20, DRIVE_FULL, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 50, DRIVE_FULL, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 19999, 8'd128, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 20000, FLOOR_RST, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 59999, FLOOR_RST + 8'd1, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 60000, 8'd0, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 119999, 8'd200, 1'b0, 1'b0, 1'b1);
      send_pass(t0 + 120000, DRIVE_FULL, 1'b0, 1'b1, 1'b0);
      send_pass(t0 + 159999, 8'd64, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 160000, 8'd64, 1'b0, 1'b0, 1'b0);
      // idle: relay forced off, then step to custom and push below zero
      send_pass(t0 + 170000, DRIVE_FULL, 1'b0, 1'b0, 1'b0);
      send_pass(t0 + 170500, 8'd0, 1'b0, 1'b1, 1'b0);
      send_pass(t0 + 170600, 8'd0, 1'b0, 1'b1, 1'b0);
      send_pass(t0 + 171000, 8'd0, 1'b1, 1'b0, 1'b0);
      send_pass(t0 + 172000, DRIVE_FULL, 1'b0, 1'b1, 1'b0);
      send_pass(t0 + 173000, 8'd90, 1'b0, 1'b0, 1'b1);
      send_pass(t0 + 174000, 8'd90, 1'b1, 1'b0, 1'b1);
      // late first profile pass: progress clamps at full scale
      send_pass(32'd500, 8'd0, 1'b0, 1'b0, 1'b1);
      send_pass(32'd1000, 8'd0, 1'b1, 1'b0, 1'b0);
      send_pass(32'd501000, 8'd77, 1'b0, 1'b0, 1'b0);
      stamp_ms = 32'd600000;
   endtask

   // custom target up to the ceiling and back
   task automatic test_target_ceiling();
      int unsigned guard;
      if (sim_running) send_pass(stamp_ms, 8'd0, 1'b1, 1'b0, 1'b0);
      while (sim_mode != MODE_CUSTOM) send_pass(stamp_ms, 8'd0, 1'b0, 1'b0, 1'b1);
      send_pass(stamp_ms, pick_drive(), 1'b1, 1'b0, 1'b0);
      guard = 0;
      while (sim_target != TARGET_MAX && guard < 600) begin
         stamp_ms += $urandom_range(0, 60);
         send_pass(stamp_ms, pick_drive(), 1'b0, $urandom_range(0, 15) == 0, 1'b1);
         guard++;
      end
      repeat (4) send_pass(stamp_ms, pick_drive(), 1'b0, 1'b0, 1'b1);
      repeat (3) send_pass(stamp_ms, pick_drive(), 1'b0, 1'b1, 1'b0);
      send_pass(stamp_ms, 8'd0, 1'b1, 1'b0, 1'b0);
   endtask

   // zero window: any nonzero elapsed time fires a switch
   task automatic test_window_zero();
      set_config(16'd0, 10'd0, 8'd0);
      send_pass(stamp_ms, 8'd1, 1'b1, 1'b0, 1'b0);
      send_pass(stamp_ms, 8'd1, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 1, 8'd1, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 1, 8'd0, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 2, 8'd128, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 3, DRIVE_FULL, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 3, 8'd0, 1'b0, 1'b0, 1'b0);
      send_pass(stamp_ms + 4, 8'd0, 1'b1, 1'b0, 1'b0);
      stamp_ms += 5;
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned goal;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else                           run_episode();
      end
   endtask

   // --------------------------------------------------------------------------
   // sequence
   // --------------------------------------------------------------------------
   initial begin
      int ph;
      logic [15:0] rw;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_panel_and_profile();
      test_target_ceiling();
      test_window_zero();

      // register settings crossed with idle patterns
      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin snd_idle_pct = 0;  stall_pct = 0;  end
            1: begin snd_idle_pct = 57; stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  stall_pct = 57; end
            default: begin snd_idle_pct = 23; stall_pct = 23; end
         endcase
         rw = 16'($urandom());
         case (ph)
            0: set_config(WINDOW_RST, MIN_SWITCH_RST, FLOOR_RST);
            1: set_config(16'd1, 10'd0, 8'd0);
            2: set_config(16'hFFFF, 10'h3FF, 8'hFF);
            3: set_config(16'd300, 10'd7, 8'd128);
            4: set_config(16'hFFFF, 10'd0, 8'd254);
            5: set_config(rw, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
            6: set_config(16'd500, 10'h3FF, 8'd0);
            default: set_config({4'd0, rw[11:0]}, 10'($urandom_range(0, 60)),
                                8'($urandom_range(0, 255)));
         endcase
         test_random_traffic(90);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (err_count == 0) $display("reflow_heater_sequencer test passed");
      else                $display("reflow_heater_sequencer test failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/rhs_pkg.sv
hw/rtl/rhs_relay.sv
hw/rtl/rhs_profile.sv
hw/rtl/rhs_panel.sv
hw/rtl/reflow_heater_sequencer.sv
tb/tb.sv
